// ===== src/fmsq_pkg.sv =====
package fmsq_pkg;

    // default sizes
    localparam int CHANNELS_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    // field widths
    localparam int STAMP_W = 63;
    localparam int TAG_W   = 32;
    localparam int CHAN_W  = 2;
    localparam int TOL_W   = 32;
    localparam int LIMIT_W = 5;

    // register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(1000000);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '0;

    // register index, taken from paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_LIMIT     = 1'b1;

    // request actions
    localparam logic ACT_DELIVER = 1'b0;
    localparam logic ACT_POP     = 1'b1;

    typedef struct packed {
        logic               action;
        logic [CHAN_W-1:0]  channel;
        logic [STAMP_W-1:0] frame_stamp;
        logic [TAG_W-1:0]   frame_tag;
    } req_t;

    typedef struct packed {
        logic               set_valid;
        logic [CHAN_W-1:0]  out_channel;
        logic [STAMP_W-1:0] out_stamp;
        logic [TAG_W-1:0]   out_tag;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [TAG_W-1:0]   tag;
    } frame_t;

    typedef struct packed {
        logic [TOL_W-1:0]   tolerance_ns;
        logic [LIMIT_W-1:0] queue_limit;
    } cfg_t;

endpackage

// ===== src/fmsq_ram.sv =====
module fmsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fmsq_cfg.sv =====
module fmsq_cfg
    import fmsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [TOL_W-1:0]   tol_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TOLERANCE: tol_reg   <= pwdata[TOL_W-1:0];
                REG_LIMIT:     limit_reg <= pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TOLERANCE: prdata = APB_DATA_W'(tol_reg);
            REG_LIMIT:     prdata = APB_DATA_W'(limit_reg);
        endcase
    end

    assign cfg = '{tolerance_ns: tol_reg, queue_limit: limit_reg};

endmodule

// ===== src/multi_channel_frame_sync_queue_top.sv =====
// Frame sync queue: a deliver beat stores one channel's frame stamp and buffer tag in
// that channel's slot; when every slot holds a nonzero stamp and the spread (largest
// minus smallest) is strictly below tolerance_ns, the whole set is copied into a
// circular queue of sets and all slots are cleared. With one channel every frame
// matches. A pop beat returns the oldest set as CHANNELS response beats in channel
// order (last on the final one), or a single beat with set_valid low when the queue
// is empty. When the queue holds queue_limit sets (QUEUE_DEPTH if queue_limit is 0 or
// above the depth) the oldest set is dropped before a push. Slots live in a
// CHANNELS-entry memory with per-entry valid flops, sets in a QUEUE_DEPTH*CHANNELS
// entry memory; both have one registered read port, and that port sets the timing.
// A deliver is stored at accept, then each slot is read and used in turn and the
// match is tested; a matching set is copied into the queue, each slot read and then
// written in turn. A pop reads each beat of the oldest set into the output register,
// waiting while it is full. One request is worked on at a time; the last response
// beat may still wait in the output register while the next request is taken. Queue
// entries are never cleared, so the block is ready right after reset. Registers:
// tolerance_ns at byte 0, queue_limit at byte 4; write only while the block is idle.
module multi_channel_frame_sync_queue_top
    import fmsq_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int  SAW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int  HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int  CNW    = $clog2(QUEUE_DEPTH + 1);
    localparam int  QDEPTH = QUEUE_DEPTH * CHANNELS;
    localparam int  QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam bit  SINGLE = (CHANNELS == 1);
    localparam int  FW     = $bits(frame_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_USE,
        S_MATCH,
        S_BASE,
        S_COPY_RD,
        S_COPY_WR,
        S_POP_RD,
        S_POP_LD
    } state_t;

    cfg_t cfg;

    fmsq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t                state_reg,     state_next;
    logic [SAW-1:0]        chan_reg,      chan_next;
    logic [QAW-1:0]        qaddr_reg,     qaddr_next;
    logic [HW-1:0]         head_reg,      head_next;
    logic [CNW-1:0]        count_reg,     count_next;
    logic [CHANNELS-1:0]   slot_vld_reg,  slot_vld_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg,       rsp_next;
    logic [STAMP_W-1:0]    lo_reg,        lo_next;
    logic [STAMP_W-1:0]    hi_reg,        hi_next;

    // slot memory
    logic                  slot_we;
    logic [SAW-1:0]        slot_waddr;
    frame_t                slot_wdata;
    logic                  slot_re;
    logic [FW-1:0]         slot_rdata;
    frame_t                slot_word;

    // set queue memory
    logic                  queue_we;
    logic                  queue_re;
    logic [FW-1:0]         queue_rdata;
    frame_t                queue_word;

    logic                  req_fire;
    logic                  out_free;
    logic                  chan_last;
    logic                  chan_ok;
    logic [HW-1:0]         head_inc;
    logic [CNW-1:0]        limit_eff;
    logic                  drop;
    logic [CNW:0]          pos_sum;
    logic [HW-1:0]         pos;
    logic [STAMP_W-1:0]    spread;
    logic                  matched;

    fmsq_ram #(
        .WIDTH (FW),
        .DEPTH (CHANNELS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (chan_reg),
        .rdata (slot_rdata)
    );

    fmsq_ram #(
        .WIDTH (FW),
        .DEPTH (QDEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (queue_we),
        .waddr (qaddr_reg),
        .wdata (slot_word),
        .re    (queue_re),
        .raddr (qaddr_reg),
        .rdata (queue_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a slot that was cleared reads as zero
    assign slot_word  = slot_vld_reg[chan_reg] ? frame_t'(slot_rdata) : '0;
    assign queue_word = frame_t'(queue_rdata);

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign chan_last = (chan_reg == SAW'(CHANNELS - 1));
    assign chan_ok   = (32'(req.channel) < CHANNELS);
    assign head_inc  = (head_reg == HW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // effective limit: 0 or beyond the depth means full depth
    assign limit_eff = (cfg.queue_limit == '0 || 32'(cfg.queue_limit) > QUEUE_DEPTH)
                     ? CNW'(QUEUE_DEPTH) : CNW'(cfg.queue_limit);
    assign drop      = (count_reg >= limit_eff) && (count_reg != '0);

    // tail position, sum stays below twice the depth
    assign pos_sum = (CNW+1)'(head_reg) + (CNW+1)'(count_reg);
    assign pos     = (pos_sum >= (CNW+1)'(QUEUE_DEPTH))
                   ? HW'(pos_sum - (CNW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);

    // match test on the scanned extremes
    assign spread  = hi_reg - lo_reg;
    assign matched = SINGLE ||
                     ((lo_reg != '0) && (spread < STAMP_W'(cfg.tolerance_ns)));

    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        qaddr_next     = qaddr_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        slot_vld_next  = slot_vld_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        slot_we        = 1'b0;
        slot_waddr     = SAW'(req.channel);
        slot_wdata     = '{stamp: req.frame_stamp, tag: req.frame_tag};
        slot_re        = 1'b0;
        queue_we       = 1'b0;
        queue_re       = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    chan_next = '0;
                    if (req.action == ACT_POP)
                    begin
                        qaddr_next = QAW'(head_reg * CHANNELS);
                        state_next = S_POP_RD;
                    end
                    else if (chan_ok)
                    begin
                        // store first, then scan all slots including this one
                        slot_we                            = 1'b1;
                        slot_vld_next[SAW'(req.channel)] = 1'b1;
                        state_next                         = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                slot_re    = 1'b1;
                state_next = S_SCAN_USE;
            end
            S_SCAN_USE:
            begin
                if (chan_reg == '0)
                begin
                    lo_next = slot_word.stamp;
                    hi_next = slot_word.stamp;
                end
                else
                begin
                    if (slot_word.stamp < lo_reg)
                    begin
                        lo_next = slot_word.stamp;
                    end
                    if (slot_word.stamp > hi_reg)
                    begin
                        hi_next = slot_word.stamp;
                    end
                end
                if (chan_last)
                begin
                    state_next = S_MATCH;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_MATCH:
            begin
                if (matched)
                begin
                    // make room by dropping the oldest set
                    if (drop)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                    state_next = S_BASE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BASE:
            begin
                qaddr_next = QAW'(pos * CHANNELS);
                chan_next  = '0;
                state_next = S_COPY_RD;
            end
            S_COPY_RD:
            begin
                slot_re    = 1'b1;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                queue_we   = 1'b1;
                qaddr_next = qaddr_reg + 1'b1;
                if (chan_last)
                begin
                    slot_vld_next = '0;
                    count_next    = count_reg + 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            S_POP_RD:
            begin
                if (out_free)
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next       = '{set_valid: 1'b0, out_channel: '0,
                                           out_stamp: '0, out_tag: '0, last: 1'b1};
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        queue_re   = 1'b1;
                        state_next = S_POP_LD;
                    end
                end
            end
            S_POP_LD:
            begin
                // output register was freed when the read was issued
                rsp_next       = '{set_valid: 1'b1, out_channel: CHAN_W'(chan_reg),
                                   out_stamp: queue_word.stamp, out_tag: queue_word.tag,
                                   last: chan_last};
                rsp_valid_next = 1'b1;
                qaddr_next     = qaddr_reg + 1'b1;
                if (chan_last)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_POP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= '0;
            qaddr_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            slot_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            qaddr_reg     <= qaddr_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            slot_vld_reg  <= slot_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // scan extremes, no reset needed
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // queue never holds more sets than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNW'(QUEUE_DEPTH))
    else $error("set count beyond queue depth");

    // an empty-queue beat is always the final beat of its pop
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.set_valid |-> rsp_reg.last)
    else $error("empty-queue beat without last");

    // completing a set copy leaves every slot cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY_WR) && chan_last |=> (slot_vld_reg == '0))
    else $error("slots not cleared after push");

    // count moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + 1'b1) ||
                 (count_reg + 1'b1 == $past(count_reg)))
    else $error("set count jumped");

endmodule
